@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PKA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pka implication check failed");

// next-cycle implication, disabled during reset
`define PKA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pka next-cycle check failed");

`endif

@@ rtl/pka_pkg.sv @@
package pka_pkg;

   localparam int MAX_KEYS    = 8;
   localparam int KEY_AW      = $clog2(MAX_KEYS);
   localparam int CNT_W       = KEY_AW + 1;
   localparam int COLOR_KEY_W = 56;
   localparam int SIZE_KEY_W  = 40;
   localparam int TIME_W      = 24;
   localparam int DIVD_W      = 40;
   localparam int CSR_W       = 48;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // request modes
   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_COLOR = 2'd2;
   localparam logic [1:0] MODE_SIZE  = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_LIFETIME     = 3'd0;
   localparam logic [2:0] CSR_START_VEL    = 3'd1;
   localparam logic [2:0] CSR_ACCEL        = 3'd2;
   localparam logic [2:0] CSR_ANGULAR      = 3'd3;
   localparam logic [2:0] CSR_FRAME_TIMING = 3'd4;
   localparam logic [2:0] CSR_COLOR_PERIOD = 3'd5;
   localparam logic [2:0] CSR_SIZE_PERIOD  = 3'd6;
   localparam logic [2:0] CSR_FLAGS        = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT_RD,
      ST_INTEG_ACC,
      ST_INTEG_VEL,
      ST_INTEG_POS,
      ST_FRAME,
      ST_FRAME_DIV,
      ST_PERIOD,
      ST_MOD_DIV,
      ST_CHECK,
      ST_RD_NEXT,
      ST_RD_A,
      ST_RD_B,
      ST_FACTOR,
      ST_FACT_DIV,
      ST_LERP_MUL,
      ST_LERP_ADD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [TIME_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIVD_W-1:0] quotient;
      logic [TIME_W-1:0] remainder;
   } div_rsp_type;

   // saturating time add
   function automatic logic [TIME_W-1:0] tadd(input logic [TIME_W-1:0] a,
                                              input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

@@ rtl/pka_req_if.sv @@
interface pka_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [23:0]        delta_time;
   logic signed [31:0] init_pos_x;
   logic signed [31:0] init_pos_y;
   logic signed [31:0] init_pos_z;
   logic [2:0]         key_index;
   logic [23:0]        key_time;
   logic [31:0]        key_value;

   modport source (output valid, mode, delta_time, init_pos_x, init_pos_y, init_pos_z,
                   key_index, key_time, key_value, input ready);
   modport sink (input valid, mode, delta_time, init_pos_x, init_pos_y, init_pos_z,
                 key_index, key_time, key_value, output ready);
endinterface

@@ rtl/pka_rsp_if.sv @@
interface pka_rsp_if;
   logic               valid;
   logic               ready;
   logic               alive;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [15:0] angle_out;
   logic [7:0]         frame_out;
   logic [31:0]        color_out;
   logic [15:0]        size_out;

   modport source (output valid, alive, pos_x, pos_y, pos_z, angle_out, frame_out,
                   color_out, size_out, input ready);
   modport sink (input valid, alive, pos_x, pos_y, pos_z, angle_out, frame_out,
                 color_out, size_out, output ready);
endinterface

@@ rtl/particle_keyframe_animator_top.sv @@
// A tick runs the integration on one shared multiplier, then up to five passes of the serial
// divider (frame, two restart remainders, two factors).
// One item in flight; the next is taken once its result sits in the output register.
// Reset (synchronous, active high) initialises the configuration, control and particle state
// registers; datapath and output payload registers are not reset, and the key tables are
// undefined until loaded and get no clearing pass.
`include "assert_macros.svh"

module particle_keyframe_animator_top (
   input  logic                        clock,
   input  logic                        reset,
   pka_req_if.sink                     req_chan,
   pka_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [pka_pkg::CSR_W-1:0]   csr_wdata
);
   import pka_pkg::*;

   // configuration
   logic [23:0] lifetime_ff, color_period_ff, size_period_ff;
   logic [47:0] start_vel_ff, accel_ff, angular_ff;
   logic [31:0] frame_timing_ff;
   logic [7:0]  flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff     <= 24'h010000;
         start_vel_ff    <= '0;
         accel_ff        <= '0;
         angular_ff      <= '0;
         frame_timing_ff <= 32'h00010000;
         color_period_ff <= '0;
         size_period_ff  <= '0;
         flags_ff        <= 8'h11;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIFETIME:     lifetime_ff     <= csr_wdata[23:0];
            CSR_START_VEL:    start_vel_ff    <= csr_wdata[47:0];
            CSR_ACCEL:        accel_ff        <= csr_wdata[47:0];
            CSR_ANGULAR:      angular_ff      <= csr_wdata[47:0];
            CSR_FRAME_TIMING: frame_timing_ff <= csr_wdata[31:0];
            CSR_COLOR_PERIOD: color_period_ff <= csr_wdata[23:0];
            CSR_SIZE_PERIOD:  size_period_ff  <= csr_wdata[23:0];
            CSR_FLAGS:        flags_ff        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // particle state
   state_type          state_ff, state_in;
   logic [23:0]        lived_ff, lived_in;
   logic [23:0]        anim_t_ff [2], anim_t_in [2];
   logic signed [24:0] left_ff [2], left_in [2];
   logic [KEY_AW-1:0]  cursor_ff [2], cursor_in [2];
   logic               has_next_ff [2], has_next_in [2];
   logic [15:0]        vel_ff [3], vel_in [3];
   logic [31:0]        pos_ff [3], pos_in [3];
   logic [15:0]        angle_ff, angle_in;
   logic [15:0]        speed_ff, speed_in;
   logic [7:0]         frame_ff, frame_in;
   logic [31:0]        color_ff, color_in;
   logic [15:0]        size_ff, size_in;
   logic               alive_ff, alive_in;
   logic               sel_ff, sel_in;
   logic [1:0]         idx_ff, idx_in;

   // working registers
   logic [23:0]        dt_ff, dt_in;
   logic signed [49:0] prod_ff;
   logic signed [24:0] mul_a, mul_b;
   logic [COLOR_KEY_W-1:0] keya_ff, keya_in, keyb_ff, keyb_in;
   logic [16:0]        f_ff, f_in;
   logic [31:0]        lerp_ff, lerp_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_alive_ff;
   logic [31:0] rsp_pos_ff [3];
   logic [15:0] rsp_angle_ff;
   logic [7:0]  rsp_frame_ff;
   logic [31:0] rsp_color_ff;
   logic [15:0] rsp_size_ff;
   logic        rsp_load;

   // key tables and divider
   logic                   color_we, size_we;
   logic [KEY_AW-1:0]      key_raddr;
   logic [COLOR_KEY_W-1:0] color_rdata;
   logic [SIZE_KEY_W-1:0]  size_rdata;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   logic req_fire;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   pka_ram #(.WIDTH(COLOR_KEY_W), .DEPTH(MAX_KEYS)) u_color_keys (
      .clock (clock),
      .we    (color_we),
      .waddr (req_chan.key_index[KEY_AW-1:0]),
      .wdata ({req_chan.key_value, req_chan.key_time}),
      .raddr (key_raddr),
      .rdata (color_rdata)
   );

   pka_ram #(.WIDTH(SIZE_KEY_W), .DEPTH(MAX_KEYS)) u_size_keys (
      .clock (clock),
      .we    (size_we),
      .waddr (req_chan.key_index[KEY_AW-1:0]),
      .wdata ({req_chan.key_value[15:0], req_chan.key_time}),
      .raddr (key_raddr),
      .rdata (size_rdata)
   );

   pka_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // sequencer
   always_comb begin
      logic [23:0]            lived_new, period, last_t, next_t, tpf;
      logic [7:0]             nf;
      logic [CNT_W-1:0]       cnt_c, cnt_s, cnt, cur1;
      logic [COLOR_KEY_W-1:0] key_rd;
      logic [15:0]            base, sat, sa, sb;
      logic signed [33:0]     vsum;
      logic signed [25:0]     nl;
      logic [24:0]            nmag;
      logic [16:0]            diff;
      logic [49:0]            lsum;

      state_in    = state_ff;
      lived_in    = lived_ff;
      anim_t_in   = anim_t_ff;
      left_in     = left_ff;
      cursor_in   = cursor_ff;
      has_next_in = has_next_ff;
      vel_in      = vel_ff;
      pos_in      = pos_ff;
      angle_in    = angle_ff;
      speed_in    = speed_ff;
      frame_in    = frame_ff;
      color_in    = color_ff;
      size_in     = size_ff;
      alive_in    = alive_ff;
      sel_in      = sel_ff;
      idx_in      = idx_ff;
      dt_in       = dt_ff;
      keya_in     = keya_ff;
      keyb_in     = keyb_ff;
      f_in        = f_ff;
      lerp_in     = lerp_ff;
      rsp_load    = 1'b0;
      color_we    = 1'b0;
      size_we     = 1'b0;
      key_raddr   = '0;
      mul_a       = '0;
      mul_b       = '0;
      div_req     = '0;

      lived_new = tadd(lived_ff, req_chan.delta_time);
      tpf       = frame_timing_ff[23:0];
      nf        = frame_timing_ff[31:24];
      cnt_c     = {1'b0, flags_ff[4:2]} + CNT_W'(1);
      cnt_s     = {1'b0, flags_ff[7:5]} + CNT_W'(1);
      if (cnt_c > CNT_W'(MAX_KEYS)) cnt_c = CNT_W'(MAX_KEYS);
      if (cnt_s > CNT_W'(MAX_KEYS)) cnt_s = CNT_W'(MAX_KEYS);
      cnt       = sel_ff ? cnt_s : cnt_c;
      period    = sel_ff ? size_period_ff : color_period_ff;
      cur1      = {1'b0, cursor_ff[sel_ff]} + CNT_W'(1);
      key_rd    = sel_ff ? {16'b0, size_rdata} : color_rdata;
      base      = (idx_ff == 2'd3) ? speed_ff : vel_ff[idx_ff];
      vsum      = $signed({{18{base[15]}}, base}) + $signed(prod_ff[49:16]);
      sat       = (vsum > 34'sd32767) ? 16'h7fff :
                  (vsum < -34'sd32768) ? 16'h8000 : vsum[15:0];
      nl        = $signed({left_ff[sel_ff][24], left_ff[sel_ff]}) -
                  $signed({2'b00, dt_ff});
      nmag      = 25'(-nl);
      last_t    = (cursor_ff[sel_ff] == '0) ? 24'd0 : keya_ff[23:0];
      next_t    = keyb_ff[23:0];
      sa        = sel_ff ? keya_ff[39:24] : {8'b0, keya_ff[24 + idx_ff*8 +: 8]};
      sb        = sel_ff ? keyb_ff[39:24] : {8'b0, keyb_ff[24 + idx_ff*8 +: 8]};
      diff      = {1'b0, sb} - {1'b0, sa};
      lsum      = {18'b0, sa, 16'b0} + 50'(prod_ff) + 50'd32768;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               alive_in = 1'b1;
               dt_in    = req_chan.delta_time;
               unique case (req_chan.mode)
                  MODE_INIT: begin
                     lived_in       = '0;
                     anim_t_in[0]   = '0;
                     anim_t_in[1]   = '0;
                     vel_in[0]      = start_vel_ff[15:0];
                     vel_in[1]      = start_vel_ff[31:16];
                     vel_in[2]      = start_vel_ff[47:32];
                     speed_in       = angular_ff[31:16];
                     angle_in       = angular_ff[15:0];
                     cursor_in[0]   = '0;
                     cursor_in[1]   = '0;
                     has_next_in[0] = cnt_c > CNT_W'(1);
                     has_next_in[1] = cnt_s > CNT_W'(1);
                     left_in[0]     = $signed({1'b0, color_period_ff});
                     left_in[1]     = $signed({1'b0, size_period_ff});
                     pos_in[0]      = req_chan.init_pos_x;
                     pos_in[1]      = req_chan.init_pos_y;
                     pos_in[2]      = req_chan.init_pos_z;
                     frame_in       = '0;
                     state_in       = ST_INIT_RD;
                  end
                  MODE_TICK: begin
                     lived_in     = lived_new;
                     anim_t_in[0] = tadd(anim_t_ff[0], req_chan.delta_time);
                     anim_t_in[1] = tadd(anim_t_ff[1], req_chan.delta_time);
                     idx_in       = '0;
                     if (!flags_ff[0] && lived_new > lifetime_ff) begin
                        alive_in = 1'b0;
                        state_in = ST_OUT;
                     end else if (!flags_ff[0]) begin
                        state_in = ST_INTEG_ACC;
                     end else begin
                        state_in = ST_FRAME;
                     end
                  end
                  MODE_COLOR: begin
                     color_we = int'(req_chan.key_index) < MAX_KEYS;
                     state_in = ST_OUT;
                  end
                  MODE_SIZE: begin
                     size_we  = int'(req_chan.key_index) < MAX_KEYS;
                     state_in = ST_OUT;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_INIT_RD: begin
            color_in = color_rdata[55:24];
            size_in  = size_rdata[39:24];
            state_in = ST_OUT;
         end
         // integration: accel*dt, then vel*dt, per axis and for the angle
         ST_INTEG_ACC: begin
            unique case (idx_ff)
               2'd0:    mul_a = 25'($signed(accel_ff[15:0]));
               2'd1:    mul_a = 25'($signed(accel_ff[31:16]));
               2'd2:    mul_a = 25'($signed(accel_ff[47:32]));
               default: mul_a = 25'($signed(angular_ff[47:32]));
            endcase
            mul_b    = $signed({1'b0, dt_ff});
            state_in = ST_INTEG_VEL;
         end
         ST_INTEG_VEL: begin
            if (idx_ff == 2'd3) begin
               speed_in = sat;
            end else begin
               vel_in[idx_ff] = sat;
            end
            mul_a    = 25'($signed(sat));
            mul_b    = $signed({1'b0, dt_ff});
            state_in = ST_INTEG_POS;
         end
         ST_INTEG_POS: begin
            if (idx_ff == 2'd3) begin
               angle_in = angle_ff + prod_ff[31:16];
               state_in = ST_FRAME;
            end else begin
               pos_in[idx_ff] = pos_ff[idx_ff] + prod_ff[39:8];
               idx_in         = idx_ff + 2'd1;
               state_in       = ST_INTEG_ACC;
            end
         end
         // sprite frame
         ST_FRAME: begin
            sel_in = 1'b0;
            if (!flags_ff[1]) begin
               state_in = ST_PERIOD;
            end else if (tpf == '0) begin
               frame_in = (nf == '0) ? 8'd0 : nf - 8'd1;
               state_in = ST_PERIOD;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {16'b0, lived_ff};
               div_req.divisor  = tpf;
               state_in         = ST_FRAME_DIV;
            end
         end
         ST_FRAME_DIV: begin
            if (div_rsp.done) begin
               if (nf == '0) begin
                  frame_in = '0;
               end else if (div_rsp.quotient >= {32'b0, nf}) begin
                  frame_in = nf - 8'd1;
               end else begin
                  frame_in = div_rsp.quotient[7:0];
               end
               state_in = ST_PERIOD;
            end
         end
         // keyframe animation, color then size
         ST_PERIOD: begin
            state_in = ST_CHECK;
            if (period != '0) begin
               if (nl <= 26'sd0) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {15'b0, nmag};
                  div_req.divisor  = period;
                  state_in         = ST_MOD_DIV;
               end else begin
                  left_in[sel_ff] = nl[24:0];
               end
            end
         end
         ST_MOD_DIV: begin
            if (div_rsp.done) begin
               anim_t_in[sel_ff]   = div_rsp.remainder;
               left_in[sel_ff]     = $signed({1'b0, period - div_rsp.remainder});
               cursor_in[sel_ff]   = '0;
               has_next_in[sel_ff] = cnt > CNT_W'(1);
               state_in            = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!has_next_ff[sel_ff]) begin
               sel_in   = 1'b1;
               state_in = sel_ff ? ST_OUT : ST_PERIOD;
            end else if (cur1 >= cnt) begin
               has_next_in[sel_ff] = 1'b0;
               sel_in              = 1'b1;
               state_in            = sel_ff ? ST_OUT : ST_PERIOD;
            end else begin
               key_raddr = cur1[KEY_AW-1:0];
               state_in  = ST_RD_NEXT;
            end
         end
         ST_RD_NEXT: begin
            if (anim_t_ff[sel_ff] > key_rd[23:0]) begin
               cursor_in[sel_ff] = cur1[KEY_AW-1:0];
               if (cur1 + CNT_W'(1) >= cnt) begin
                  has_next_in[sel_ff] = 1'b0;
                  if (sel_ff) begin
                     size_in = key_rd[39:24];
                  end else begin
                     color_in = key_rd[55:24];
                  end
                  sel_in   = 1'b1;
                  state_in = sel_ff ? ST_OUT : ST_PERIOD;
               end else begin
                  keya_in   = key_rd;
                  key_raddr = KEY_AW'(cur1 + CNT_W'(1));
                  state_in  = ST_RD_B;
               end
            end else begin
               keyb_in   = key_rd;
               key_raddr = cursor_ff[sel_ff];
               state_in  = ST_RD_A;
            end
         end
         ST_RD_A: begin
            keya_in  = key_rd;
            state_in = ST_FACTOR;
         end
         ST_RD_B: begin
            keyb_in  = key_rd;
            state_in = ST_FACTOR;
         end
         ST_FACTOR: begin
            idx_in   = '0;
            lerp_in  = '0;
            state_in = ST_LERP_MUL;
            if (next_t <= last_t) begin
               f_in = 17'h10000;
            end else if (anim_t_ff[sel_ff] <= last_t) begin
               f_in = '0;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {anim_t_ff[sel_ff] - last_t, 16'b0};
               div_req.divisor  = next_t - last_t;
               state_in         = ST_FACT_DIV;
            end
         end
         ST_FACT_DIV: begin
            if (div_rsp.done) begin
               f_in     = (div_rsp.quotient > 40'h10000) ? 17'h10000
                                                          : div_rsp.quotient[16:0];
               state_in = ST_LERP_MUL;
            end
         end
         // one channel per pass: a + (b - a)*f, rounded
         ST_LERP_MUL: begin
            mul_a    = 25'($signed(diff));
            mul_b    = $signed({8'b0, f_ff});
            state_in = ST_LERP_ADD;
         end
         ST_LERP_ADD: begin
            if (sel_ff) begin
               size_in  = lsum[31:16];
               state_in = ST_OUT;
            end else begin
               lerp_in[idx_ff*8 +: 8] = lsum[23:16];
               if (idx_ff == 2'd3) begin
                  color_in = {lsum[23:16], lerp_ff[23:0]};
                  sel_in   = 1'b1;
                  state_in = ST_PERIOD;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_LERP_MUL;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and particle state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lived_ff     <= '0;
         for (int i = 0; i < 2; i++) begin
            anim_t_ff[i]   <= '0;
            left_ff[i]     <= '0;
            cursor_ff[i]   <= '0;
            has_next_ff[i] <= 1'b0;
         end
         for (int i = 0; i < 3; i++) begin
            vel_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
         angle_ff <= '0;
         speed_ff <= '0;
         frame_ff <= '0;
         color_ff <= '0;
         size_ff  <= '0;
         alive_ff <= 1'b1;
         sel_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lived_ff     <= lived_in;
         anim_t_ff    <= anim_t_in;
         left_ff      <= left_in;
         cursor_ff    <= cursor_in;
         has_next_ff  <= has_next_in;
         vel_ff       <= vel_in;
         pos_ff       <= pos_in;
         angle_ff     <= angle_in;
         speed_ff     <= speed_in;
         frame_ff     <= frame_in;
         color_ff     <= color_in;
         size_ff      <= size_in;
         alive_ff     <= alive_in;
         sel_ff       <= sel_in;
         idx_ff       <= idx_in;
      end
   end

   // datapath registers, shared multiplier, output payload
   always_ff @(posedge clock) begin
      dt_ff   <= dt_in;
      prod_ff <= mul_a * mul_b;
      keya_ff <= keya_in;
      keyb_ff <= keyb_in;
      f_ff    <= f_in;
      lerp_ff <= lerp_in;
      if (rsp_load) begin
         rsp_alive_ff <= alive_ff;
         rsp_pos_ff   <= pos_ff;
         rsp_angle_ff <= angle_ff;
         rsp_frame_ff <= frame_ff;
         rsp_color_ff <= color_ff;
         rsp_size_ff  <= size_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.alive     = rsp_alive_ff;
   assign rsp_chan.pos_x     = rsp_pos_ff[0];
   assign rsp_chan.pos_y     = rsp_pos_ff[1];
   assign rsp_chan.pos_z     = rsp_pos_ff[2];
   assign rsp_chan.angle_out = rsp_angle_ff;
   assign rsp_chan.frame_out = rsp_frame_ff;
   assign rsp_chan.color_out = rsp_color_ff;
   assign rsp_chan.size_out  = rsp_size_ff;

   // sequencer sits in one of the divider wait states
   logic div_waiting;
   assign div_waiting = (state_ff == ST_FRAME_DIV) || (state_ff == ST_MOD_DIV) ||
                        (state_ff == ST_FACT_DIV);

   // checks
   `PKA_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_chan.ready)
   `PKA_ASSERT_IMPL(a_div_start_idle, div_req.start, !div_rsp.busy)
   `PKA_ASSERT_IMPL(a_div_done_waited, div_rsp.done, div_waiting)
endmodule

@@ rtl/pka_ram.sv @@
module pka_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/pka_divider.sv @@
module pka_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  pka_pkg::div_req_type div_req,
   output pka_pkg::div_rsp_type div_rsp
);
   import pka_pkg::*;

   localparam int CW = $clog2(DIVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] dvs_ff, dvs_in;

   // one quotient bit per cycle, restoring
   always_comb begin
      logic [TIME_W:0] trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = TIME_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[TIME_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIVD_W);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;
endmodule
